// File: rtl/core/plle_pkg.sv
// ----------------------------------------------------------------------------
// plle_pkg
// Types, codes and sizes shared by the pooled linked list engine.
// ----------------------------------------------------------------------------
package plle_pkg;

    localparam int POOL_SIZE_DEF = 16;
    localparam int CMD_W         = 2;
    localparam int POS_W         = 5;
    localparam int CODE_W        = 32;
    localparam int SLOT_W        = 4;

    localparam logic [CMD_W-1:0] CMD_DISPLAY = 2'd0;
    localparam logic [CMD_W-1:0] CMD_INSERT  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DELETE  = 2'd2;

    localparam logic signed [CODE_W-1:0] END_CODE = -32'sd1;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_BADPOS   = 3'd3,
        ST_RESERVED = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        OP_DISPLAY,
        OP_INSERT,
        OP_DELETE
    } op_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_WREQ,
        S_WDATA,
        S_VREQ,
        S_VDATA,
        S_LINK,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic [CMD_W-1:0]         command;
        logic [POS_W-1:0]         position;
        logic signed [CODE_W-1:0] entry_code;
    } request_t;

    typedef struct packed {
        status_t                  status;
        logic [POS_W-1:0]         out_position;
        logic signed [CODE_W-1:0] out_code;
        logic [SLOT_W-1:0]        out_slot;
        logic                     last;
    } response_t;

    typedef struct packed {
        op_t                      op;
        logic [POS_W-1:0]         position;
        logic signed [CODE_W-1:0] entry_code;
        logic                     reserved;
    } cmd_entry_t;

endpackage

// File: rtl/core/plle_ram.sv
// ----------------------------------------------------------------------------
// plle_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module plle_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/core/plle_fifo.sv
// ----------------------------------------------------------------------------
// plle_fifo
// Small register FIFO used between the front, the back and the result port.
// ----------------------------------------------------------------------------
module plle_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_wr, do_rd;

    assign full    = (cnt_reg == CNT_W'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// File: rtl/core/plle_front.sv
// ----------------------------------------------------------------------------
// plle_front
// Accepts requests, drops unused commands, decodes the rest into the queue.
// ----------------------------------------------------------------------------
module plle_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  plle_pkg::request_t   request,
    input  logic                 q_pop,
    output logic                 q_empty,
    output plle_pkg::cmd_entry_t q_entry
);
    import plle_pkg::*;

    cmd_entry_t entry;
    logic       keep;
    logic [$bits(cmd_entry_t)-1:0] q_data;

    always_comb
    begin
        keep = 1'b1;
        unique case (request.command)
            CMD_DISPLAY: entry.op = OP_DISPLAY;
            CMD_INSERT:  entry.op = OP_INSERT;
            CMD_DELETE:  entry.op = OP_DELETE;
            default:
            begin
                entry.op = OP_DISPLAY;
                keep     = 1'b0;
            end
        endcase
        entry.position   = request.position;
        entry.entry_code = request.entry_code;
        entry.reserved   = (request.entry_code == END_CODE);
    end

    plle_fifo #(
        .WIDTH ($bits(cmd_entry_t)),
        .DEPTH (2)
    ) u_cmd_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push && keep),
        .wr_data (entry),
        .full    (full),
        .rd_en   (q_pop),
        .rd_data (q_data),
        .empty   (q_empty)
    );

    assign q_entry = cmd_entry_t'(q_data);

endmodule

// File: rtl/core/plle_back.sv
// ----------------------------------------------------------------------------
// plle_back
// Executes queued commands: walks the list, allocates and frees slots.
// ----------------------------------------------------------------------------
module plle_back #(
    parameter int POOL_SIZE = plle_pkg::POOL_SIZE_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     head_code_we,
    input  logic signed [31:0]       head_code_wdata,
    input  logic                     q_empty,
    output logic                     q_pop,
    input  plle_pkg::cmd_entry_t     q_entry,
    input  logic                     res_full,
    output logic                     res_push,
    output plle_pkg::response_t      res_data
);
    import plle_pkg::*;

    localparam int SW = $clog2(POOL_SIZE);
    localparam int CW = $clog2(POOL_SIZE + 1);
    localparam int PW = (CW + 1 > POS_W) ? CW + 1 : POS_W;

    state_t                 state_reg, state_next;
    op_t                    op_reg, op_next;
    logic [POS_W-1:0]       pos_reg, pos_next;
    logic signed [CODE_W-1:0] code_reg, code_next;
    logic [SW-1:0]          cur_reg, cur_next;
    logic [SW-1:0]          nxt_reg, nxt_next;
    logic [SW-1:0]          scan_reg, scan_next;
    logic [SW-1:0]          fresh_reg, fresh_next;
    logic [SW-1:0]          pred_reg, pred_next;
    logic [SW-1:0]          head_next_reg, head_next_next;
    logic [CW-1:0]          idx_reg, idx_next;
    logic [CW-1:0]          count_reg, count_next;
    logic [POOL_SIZE-1:0]   used_reg, used_next;
    logic signed [CODE_W-1:0] head_code_reg;
    response_t              res_reg, res_next;

    logic                   next_we;
    logic [SW-1:0]          next_waddr, next_wdata, next_rdata;
    logic                   code_we;
    logic [CODE_W-1:0]      code_rdata;
    logic [SW-1:0]          link_next;
    logic                   at_pred;
    logic [PW-1:0]          qpos_e, cnt_e;

    assign link_next = (cur_reg == '0) ? head_next_reg : next_rdata;
    assign at_pred   = (PW'(idx_reg) + 1'b1 == PW'(pos_reg));
    assign qpos_e    = PW'(q_entry.position);
    assign cnt_e     = PW'(count_reg);
    assign res_data  = res_reg;

    plle_ram #(.WIDTH(SW), .DEPTH(POOL_SIZE)) u_next_ram (
        .clk   (clk),
        .we    (next_we),
        .waddr (next_waddr),
        .wdata (next_wdata),
        .raddr (cur_reg),
        .rdata (next_rdata)
    );

    plle_ram #(.WIDTH(CODE_W), .DEPTH(POOL_SIZE)) u_code_ram (
        .clk   (clk),
        .we    (code_we),
        .waddr (fresh_reg),
        .wdata (code_reg),
        .raddr (cur_reg),
        .rdata (code_rdata)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    unique case (q_entry.op)
                        OP_DISPLAY: state_next = S_WREQ;
                        OP_INSERT:
                        begin
                            if (cnt_e + 1'b1 >= PW'(POOL_SIZE) || qpos_e < PW'(2)
                                || qpos_e > cnt_e + 1'b1 || q_entry.reserved)
                                state_next = S_EMIT;
                            else
                                state_next = S_SCAN;
                        end
                        OP_DELETE:
                        begin
                            if (cnt_e < PW'(2) || qpos_e < PW'(2) || qpos_e > cnt_e)
                                state_next = S_EMIT;
                            else
                                state_next = S_WREQ;
                        end
                        default: state_next = S_IDLE;
                    endcase
                end
            end
            S_SCAN:
            begin
                if (!used_reg[scan_reg])
                    state_next = S_WREQ;
            end
            S_WREQ: state_next = S_WDATA;
            S_WDATA:
            begin
                priority if (op_reg == OP_DISPLAY)
                    state_next = S_EMIT;
                else if (!at_pred)
                    state_next = S_WREQ;
                else if (op_reg == OP_INSERT)
                    state_next = S_LINK;
                else
                    state_next = S_VREQ;
            end
            S_VREQ:  state_next = S_VDATA;
            S_VDATA: state_next = S_EMIT;
            S_LINK:  state_next = S_EMIT;
            S_EMIT:
            begin
                if (!res_full)
                    state_next = res_reg.last ? S_IDLE : S_WREQ;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        op_next        = op_reg;
        pos_next       = pos_reg;
        code_next      = code_reg;
        cur_next       = cur_reg;
        nxt_next       = nxt_reg;
        scan_next      = scan_reg;
        fresh_next     = fresh_reg;
        pred_next      = pred_reg;
        head_next_next = head_next_reg;
        idx_next       = idx_reg;
        count_next     = count_reg;
        used_next      = used_reg;
        res_next       = res_reg;
        q_pop          = 1'b0;
        res_push       = 1'b0;
        next_we        = 1'b0;
        next_waddr     = pred_reg;
        next_wdata     = fresh_reg;
        code_we        = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop     = 1'b1;
                    op_next   = q_entry.op;
                    pos_next  = q_entry.position;
                    code_next = q_entry.entry_code;
                    cur_next  = '0;
                    idx_next  = CW'(1);
                    scan_next = '0;
                    res_next  = '{status: ST_OK, out_position: '0, out_code: '0,
                                  out_slot: '0, last: 1'b1};
                    unique case (q_entry.op)
                        OP_INSERT:
                        begin
                            priority if (cnt_e + 1'b1 >= PW'(POOL_SIZE))
                                res_next.status = ST_FULL;
                            else if (qpos_e < PW'(2) || qpos_e > cnt_e + 1'b1)
                                res_next.status = ST_BADPOS;
                            else if (q_entry.reserved)
                                res_next.status = ST_RESERVED;
                        end
                        OP_DELETE:
                        begin
                            priority if (cnt_e < PW'(2))
                                res_next.status = ST_EMPTY;
                            else if (qpos_e < PW'(2) || qpos_e > cnt_e)
                                res_next.status = ST_BADPOS;
                        end
                        default: ;
                    endcase
                end
            end
            S_SCAN:
            begin
                if (!used_reg[scan_reg])
                    fresh_next = scan_reg;
                else
                    scan_next = scan_reg + 1'b1;
            end
            S_WDATA:
            begin
                if (op_reg == OP_DISPLAY)
                begin
                    nxt_next = link_next;
                    res_next = '{status: ST_OK, out_position: POS_W'(idx_reg),
                                 out_code: (cur_reg == '0) ? head_code_reg : code_rdata,
                                 out_slot: SLOT_W'(cur_reg), last: (idx_reg == count_reg)};
                end
                else if (!at_pred)
                begin
                    cur_next = link_next;
                    idx_next = idx_reg + 1'b1;
                end
                else if (op_reg == OP_INSERT)
                begin
                    pred_next  = cur_reg;
                    next_we    = 1'b1;
                    next_waddr = fresh_reg;
                    next_wdata = link_next;
                    code_we    = 1'b1;
                end
                else
                begin
                    pred_next = cur_reg;
                    cur_next  = link_next;
                end
            end
            S_VDATA:
            begin
                if (pred_reg == '0)
                    head_next_next = next_rdata;
                else
                begin
                    next_we    = 1'b1;
                    next_wdata = next_rdata;
                end
                used_next[cur_reg] = 1'b0;
                count_next = count_reg - 1'b1;
                res_next   = '{status: ST_OK, out_position: pos_reg, out_code: code_rdata,
                               out_slot: SLOT_W'(cur_reg), last: 1'b1};
            end
            S_LINK:
            begin
                if (pred_reg == '0)
                    head_next_next = fresh_reg;
                else
                    next_we = 1'b1;
                used_next[fresh_reg] = 1'b1;
                count_next = count_reg + 1'b1;
                res_next   = '{status: ST_OK, out_position: pos_reg, out_code: code_reg,
                               out_slot: SLOT_W'(fresh_reg), last: 1'b1};
            end
            S_EMIT:
            begin
                if (!res_full)
                begin
                    res_push = 1'b1;
                    cur_next = nxt_reg;
                    idx_next = idx_reg + 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_next_reg <= SW'(1);
            count_reg     <= CW'(1);
            used_reg      <= POOL_SIZE'(3);
            head_code_reg <= 32'sd1;
        end
        else
        begin
            state_reg     <= state_next;
            head_next_reg <= head_next_next;
            count_reg     <= count_next;
            used_reg      <= used_next;
            if (head_code_we)
                head_code_reg <= head_code_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        pos_reg   <= pos_next;
        code_reg  <= code_next;
        cur_reg   <= cur_next;
        nxt_reg   <= nxt_next;
        scan_reg  <= scan_next;
        fresh_reg <= fresh_next;
        pred_reg  <= pred_next;
        idx_reg   <= idx_next;
        res_reg   <= res_next;
    end

endmodule

// File: rtl/core/pooled_linked_list_engine_core.sv
// ----------------------------------------------------------------------------
// pooled_linked_list_engine_core
// Singly linked list in a fixed slot pool with display, insert and delete.
// ----------------------------------------------------------------------------
// Requests enter through push/full and land in a two-entry command queue;
// command 3 is accepted and dropped. Results leave through empty/pop from a
// two-entry result queue: insert, delete and every error give one result,
// display gives one per node with last set on the final one.
// Each step of the list walk is a request state then a data state (registered
// read of the link RAM). A delete walks to position p, then reads the victim's
// link and unlinks it; an insert first scans upward from slot 0 for the lowest
// free slot, then walks to p and links it in. An error result is emitted
// directly from idle. Display walks and emits each node in turn.
// Reset leaves an empty list (head only), head_code 1, no clearing pass.
// When pop is held low the result queue fills and the walker waits; the
// command queue then fills and full rises.
// ----------------------------------------------------------------------------
module pooled_linked_list_engine_core #(
    parameter int POOL_SIZE = plle_pkg::POOL_SIZE_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  plle_pkg::request_t  request,
    output logic                empty,
    input  logic                pop,
    output plle_pkg::response_t response,
    input  logic                head_code_we,
    input  logic signed [31:0]  head_code_wdata
);
    import plle_pkg::*;

    cmd_entry_t q_entry;
    response_t  res_data;
    logic       q_pop, q_empty, res_push, res_full;
    logic [$bits(response_t)-1:0] rsp_bits;

    plle_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .request (request),
        .q_pop   (q_pop),
        .q_empty (q_empty),
        .q_entry (q_entry)
    );

    plle_back #(.POOL_SIZE(POOL_SIZE)) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .head_code_we    (head_code_we),
        .head_code_wdata (head_code_wdata),
        .q_empty         (q_empty),
        .q_pop           (q_pop),
        .q_entry         (q_entry),
        .res_full        (res_full),
        .res_push        (res_push),
        .res_data        (res_data)
    );

    plle_fifo #(
        .WIDTH ($bits(response_t)),
        .DEPTH (2)
    ) u_res_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (res_data),
        .full    (res_full),
        .rd_en   (pop),
        .rd_data (rsp_bits),
        .empty   (empty)
    );

    assign response = response_t'(rsp_bits);

endmodule

// File: rtl/core/plle_checker.sv
// ----------------------------------------------------------------------------
// plle_checker
// Port-level checks on the result channel of the engine.
// ----------------------------------------------------------------------------
module plle_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                empty,
    input logic                pop,
    input plle_pkg::response_t response
);
    import plle_pkg::*;

    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && response.status != ST_OK) |-> response.last)
        else $error("error result without last");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && response.status != ST_OK) |->
        (response.out_code == 0 && response.out_slot == 0 && response.out_position == 0))
        else $error("error result carries data");

    a_ok_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && response.status == ST_OK) |-> (response.out_position != 0))
        else $error("ok result with position zero");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(response)))
        else $error("stalled result changed");

endmodule

bind pooled_linked_list_engine_core plle_checker u_plle_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .empty    (empty),
    .pop      (pop),
    .response (response)
);
